FILE: rtl/dtr_pkg.sv
`default_nettype none

package dtr_pkg;

    // Node limit of the engine; row width and row count of both stores.
    localparam int NODES = 64;
    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = IDX_W + 1;

    typedef logic [NODES-1:0] t_row;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    // Operation codes of an input item.
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/dtr_if.sv
`default_nettype none

interface dtr_in_if;
    logic           valid;
    logic           ready;
    logic           operation;
    dtr_pkg::t_idx  producer_node;
    dtr_pkg::t_idx  consumer_node;

    modport source (
        output valid, operation, producer_node, consumer_node,
        input  ready
    );
    modport sink (
        input  valid, operation, producer_node, consumer_node,
        output ready
    );
endinterface

interface dtr_out_if;
    logic           valid;
    logic           ready;
    dtr_pkg::t_idx  node_index;
    dtr_pkg::t_row  dependency_mask;
    logic           last_row;

    modport source (
        output valid, node_index, dependency_mask, last_row,
        input  ready
    );
    modport sink (
        input  valid, node_index, dependency_mask, last_row,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/dag_transitive_reduction.sv
// Transitive reduction of a dependency graph of up to 64 nodes. Edge items
// (operation = add) transfer one per cycle, back to back: each does a
// read-modify-write of one row of the edge store (a 64 x 64 synchronous RAM,
// row = consumer, bit = producer) with forwarding of the previous write, and
// returns nothing. Edges with an end at or above node_count are dropped. A
// finish item runs the reduction: copy the rows into the closure RAM, close
// rows 0 to n-2 in order, then reduce and send one row per node, node 0
// first, last_row set on node n-1. Every closure and reduction row scans all
// n closure rows through the single read port of the closure RAM, one row a
// cycle, and a finish is held up by any
// stall on the output; no input is taken meanwhile. The edge store is empty
// again after a finish. node_count (0 acts as 1, above 64 acts as 64) may be
// written only while the block is idle.

`default_nettype none

module dag_transitive_reduction (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [dtr_pkg::CNT_W-1:0] i_cfg_wdata,
    dtr_in_if.sink                         i_in,
    dtr_out_if.source                      o_out
);

    localparam int NODES = dtr_pkg::NODES;
    localparam int IDX_W = dtr_pkg::IDX_W;
    localparam int CNT_W = dtr_pkg::CNT_W;

    // One-hot sequencer: load edges, copy, close rows, reduce rows.
    typedef enum logic [9:0] {
        S_LOAD  = 10'b00_0000_0001,
        S_COPY  = 10'b00_0000_0010,
        S_CROW  = 10'b00_0000_0100,
        S_CDEP  = 10'b00_0000_1000,
        S_CSCAN = 10'b00_0001_0000,
        S_CWR   = 10'b00_0010_0000,
        S_RROW  = 10'b00_0100_0000,
        S_RDEP  = 10'b00_1000_0000,
        S_RSCAN = 10'b01_0000_0000,
        S_REMIT = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration register.
    dtr_pkg::t_cnt r_node_count;
    dtr_pkg::t_cnt cfg_n;
    dtr_pkg::t_row cfg_cmask;

    // Edge store with one valid bit per row (invalid reads as zero).
    dtr_pkg::t_row mem_dir [NODES];
    logic [NODES-1:0] r_dvld, n_dvld;
    dtr_pkg::t_row r_dir_q;
    logic          r_dir_qv;
    dtr_pkg::t_row dir_eff;
    logic          dir_we;
    dtr_pkg::t_idx dir_waddr, dir_raddr;
    dtr_pkg::t_row dir_wdata;

    // Closure store.
    dtr_pkg::t_row mem_cl [NODES];
    dtr_pkg::t_row r_cl_q;
    logic          cl_we;
    dtr_pkg::t_idx cl_waddr, cl_raddr;
    dtr_pkg::t_row cl_wdata;

    // Edge load pipeline and write forwarding.
    logic          r_ld_vld, n_ld_vld;
    dtr_pkg::t_idx r_ld_row, n_ld_row;
    dtr_pkg::t_idx r_ld_bit, n_ld_bit;
    logic          r_wb_vld, n_wb_vld;
    dtr_pkg::t_idx r_wb_row, n_wb_row;
    dtr_pkg::t_row r_wb_data, n_wb_data;
    dtr_pkg::t_row ld_base, ld_new;

    // Sequencer counters and row registers.
    dtr_pkg::t_cnt r_n, n_n;
    dtr_pkg::t_row r_cmask, n_cmask;
    dtr_pkg::t_idx r_i, n_i;
    dtr_pkg::t_cnt r_j, n_j;
    logic          r_q_vld, n_q_vld;
    dtr_pkg::t_idx r_q_j, n_q_j;
    dtr_pkg::t_row r_deps, n_deps;
    dtr_pkg::t_row r_acc, n_acc;

    // Output register.
    logic          r_out_vld, n_out_vld;
    dtr_pkg::t_idx r_out_idx, n_out_idx;
    dtr_pkg::t_row r_out_mask, n_out_mask;
    logic          r_out_last, n_out_last;

    logic          in_fire;
    logic          in_scan;
    logic          scan_done;
    logic          row_last;
    logic          multi_dep;
    logic          out_free;
    logic          out_load;
    dtr_pkg::t_row red_row;

    // ------------------------------------------------------------------
    // Effective node count and its row mask
    // ------------------------------------------------------------------
    always_comb begin
        if (r_node_count == '0) begin
            cfg_n = CNT_W'(1);
        end else if (r_node_count > CNT_W'(NODES)) begin
            cfg_n = CNT_W'(NODES);
        end else begin
            cfg_n = r_node_count;
        end
        for (int k = 0; k < NODES; k++) begin
            cfg_cmask[k] = (CNT_W'(k) < cfg_n);
        end
    end

    // ------------------------------------------------------------------
    // Memories: one write, one registered read each cycle
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            mem_dir[dir_waddr] <= dir_wdata;
        end
        r_dir_q  <= mem_dir[dir_raddr];
        r_dir_qv <= r_dvld[dir_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cl_we) begin
            mem_cl[cl_waddr] <= cl_wdata;
        end
        r_cl_q <= mem_cl[cl_raddr];
    end

    assign dir_eff = r_dir_qv ? r_dir_q : '0;

    // ------------------------------------------------------------------
    // Handshake and shared terms
    // ------------------------------------------------------------------
    assign i_in.ready = (r_state == S_LOAD);
    assign in_fire    = i_in.valid && i_in.ready;

    assign o_out.valid           = r_out_vld;
    assign o_out.node_index      = r_out_idx;
    assign o_out.dependency_mask = r_out_mask;
    assign o_out.last_row        = r_out_last;

    assign out_free = !r_out_vld || o_out.ready;

    assign in_scan   = (r_state == S_COPY) || (r_state == S_CSCAN) || (r_state == S_RSCAN);
    assign scan_done = (r_j == r_n) && !r_q_vld;
    assign row_last  = ({1'b0, r_i} == (r_n - CNT_W'(1)));

    // A row with two or more direct dependencies gets reduced.
    assign multi_dep = |(r_deps & (r_deps - dtr_pkg::t_row'(1)));
    assign red_row   = multi_dep ? (r_deps & ~r_acc) : r_deps;

    // Edge RMW: take the previous write when it hit the same row.
    assign ld_base = (r_wb_vld && (r_wb_row == r_ld_row)) ? r_wb_data : dir_eff;
    assign ld_new  = ld_base | (dtr_pkg::t_row'(1) << r_ld_bit);

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_dvld     = r_dvld;
        n_n        = r_n;
        n_cmask    = r_cmask;
        n_i        = r_i;
        n_j        = r_j;
        n_q_vld    = 1'b0;
        n_q_j      = r_q_j;
        n_deps     = r_deps;
        n_acc      = r_acc;
        n_out_idx  = r_out_idx;
        n_out_mask = r_out_mask;
        n_out_last = r_out_last;
        n_out_vld  = r_out_vld && !o_out.ready;
        out_load   = 1'b0;

        cl_we    = 1'b0;
        cl_waddr = r_i;
        cl_wdata = r_acc;
        cl_raddr = r_j[IDX_W-1:0];

        // Edge load: stage one reads the consumer row, stage two writes it.
        n_ld_vld = in_fire && (i_in.operation == dtr_pkg::OP_ADD)
                && ({1'b0, i_in.producer_node} < cfg_n)
                && ({1'b0, i_in.consumer_node} < cfg_n);
        n_ld_row = i_in.consumer_node;
        n_ld_bit = i_in.producer_node;

        dir_we    = r_ld_vld;
        dir_waddr = r_ld_row;
        dir_wdata = ld_new;
        n_wb_vld  = r_ld_vld;
        n_wb_row  = r_ld_row;
        n_wb_data = ld_new;
        if (r_ld_vld) begin
            n_dvld[r_ld_row] = 1'b1;
        end

        if (r_state == S_LOAD) begin
            dir_raddr = i_in.consumer_node;
        end else if (r_state == S_COPY) begin
            dir_raddr = r_j[IDX_W-1:0];
        end else begin
            dir_raddr = r_i;
        end

        // Row scan: issue one read per cycle for rows 0 to n-1.
        if (in_scan && (r_j < r_n)) begin
            n_q_vld = 1'b1;
            n_q_j   = r_j[IDX_W-1:0];
            n_j     = r_j + CNT_W'(1);
        end

        unique case (r_state)
            S_LOAD: begin
                if (in_fire && (i_in.operation == dtr_pkg::OP_FINISH)) begin
                    n_n     = cfg_n;
                    n_cmask = cfg_cmask;
                    n_i     = '0;
                    n_j     = '0;
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                if (r_q_vld) begin
                    cl_we    = 1'b1;
                    cl_waddr = r_q_j;
                    cl_wdata = dir_eff & r_cmask;
                end
                if (scan_done) begin
                    n_i     = '0;
                    n_state = (r_n == CNT_W'(1)) ? S_RROW : S_CROW;
                end
            end
            S_CROW: begin
                n_state = S_CDEP;
            end
            S_CDEP: begin
                n_deps  = dir_eff & r_cmask;
                n_acc   = dir_eff & r_cmask;
                n_j     = '0;
                n_state = S_CSCAN;
            end
            S_CSCAN: begin
                if (r_q_vld && r_deps[r_q_j]) begin
                    n_acc = r_acc | r_cl_q;
                end
                if (scan_done) begin
                    n_state = S_CWR;
                end
            end
            S_CWR: begin
                cl_we    = 1'b1;
                cl_waddr = r_i;
                cl_wdata = r_acc;
                if ({1'b0, r_i} == (r_n - CNT_W'(2))) begin
                    n_i     = '0;
                    n_state = S_RROW;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_CROW;
                end
            end
            S_RROW: begin
                n_state = S_RDEP;
            end
            S_RDEP: begin
                n_deps  = dir_eff & r_cmask;
                n_acc   = '0;
                n_j     = '0;
                n_state = S_RSCAN;
            end
            S_RSCAN: begin
                if (r_q_vld && r_deps[r_q_j]) begin
                    n_acc = r_acc | r_cl_q;
                end
                if (scan_done) begin
                    n_state = S_REMIT;
                end
            end
            S_REMIT: begin
                // Hold the row until the output register frees up.
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_vld  = 1'b1;
                    n_out_idx  = r_i;
                    n_out_mask = red_row;
                    n_out_last = row_last;
                    if (row_last) begin
                        n_dvld  = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_i     = r_i + IDX_W'(1);
                        n_state = S_RROW;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_node_count <= CNT_W'(NODES);
            r_dvld       <= '0;
            r_ld_vld     <= 1'b0;
            r_wb_vld     <= 1'b0;
            r_n          <= CNT_W'(NODES);
            r_i          <= '0;
            r_j          <= '0;
            r_q_vld      <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            r_dvld    <= n_dvld;
            r_ld_vld  <= n_ld_vld;
            r_wb_vld  <= n_wb_vld;
            r_n       <= n_n;
            r_i       <= n_i;
            r_j       <= n_j;
            r_q_vld   <= n_q_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ld_row   <= n_ld_row;
        r_ld_bit   <= n_ld_bit;
        r_wb_row   <= n_wb_row;
        r_wb_data  <= n_wb_data;
        r_cmask    <= n_cmask;
        r_q_j      <= n_q_j;
        r_deps     <= n_deps;
        r_acc      <= n_acc;
        r_out_idx  <= n_out_idx;
        r_out_mask <= n_out_mask;
        r_out_last <= n_out_last;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ld_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ld_vld |-> $past(in_fire))
        else $error("edge write without an accepted edge");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j <= r_n)
        else $error("row scan ran past the node count");

    a_close_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CWR) |-> (({1'b0, r_i} + CNT_W'(2)) <= r_n))
        else $error("closure written for the last row or beyond");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && row_last) |=> ((r_state == S_LOAD) && (r_dvld == '0)))
        else $error("edge store not empty after the last row");

endmodule

`default_nettype wire
